[design/cdu_pkg.sv]
// ----------------------------------------------------------------------------
// cdu_pkg: shared types, constants and functions for the calendar date unit
// Holds the controller/datapath command and status structs, the controller
// states and the small calendar lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cdu_pkg;

    // Field widths of one transaction
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int WDAY_W   = 3;

    // Default width of the day count
    localparam int ADD_DAYS_BITS_DEF = 12;

    // Shared constant divider: remainder and quotient widths
    localparam int REM_W = 15;
    localparam int QUO_W = 8;
    // Width of the year modulo 400
    localparam int R400_W = 9;

    // Reciprocal multipliers: quotient = (x * MUL) >> SH, exact over the
    // dividend ranges used here (years up to 16783, Zeller sums up to 1069)
    localparam int RCP_W  = 13;
    localparam int PROD_W = REM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP100_MUL = RCP_W'(5243);
    localparam logic [RCP_W-1:0] RCP7_MUL   = RCP_W'(1171);
    localparam int RCP400_SH = 21;
    localparam int RCP100_SH = 19;
    localparam int RCP7_SH   = 13;

    // Calendar limits
    localparam logic [MONTH_W-1:0]  MONTH_JAN  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0]  MONTH_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0]  MONTH_DEC  = MONTH_W'(12);
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
    localparam logic [R400_W-1:0]   R400_LAST  = R400_W'(399);

    // Divisor selection of the shared divider
    typedef enum logic [1:0] {
        DIV_400,
        DIV_100,
        DIV_7
    } t_div_sel;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Q400,
        ST_R400,
        ST_CHECK,
        ST_Q100,
        ST_R100,
        ST_SUM,
        ST_Q7,
        ST_R7,
        ST_MONTH,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;        // capture a new transaction
        logic             div_quo;     // quotient by reciprocal multiply
        logic             div_rem;     // subtract quotient times divisor
        t_div_sel         div_sel;
        logic             load_yy;     // latch validity, start the century split
        logic             load_w;      // load the Zeller sum
        logic             month_step;  // retire one month of the day count
        logic             out_load;    // register the result
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic date_ok;
        logic month_fit;
    } t_dp_sts;

    // Constant divisor of the shared divider
    function automatic logic [REM_W-1:0] div_const(input t_div_sel sel);
        logic [REM_W-1:0] base;
        case (sel)
            DIV_400: base = REM_W'(400);
            DIV_100: base = REM_W'(100);
            DIV_7:   base = REM_W'(7);
            default: base = REM_W'(7);
        endcase
        return base;
    endfunction

    // Leap rule on the year modulo 400
    function automatic logic leap_r400(input logic [R400_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != R400_W'(100)) &&
               (r != R400_W'(200)) && (r != R400_W'(300));
    endfunction

    // Month length; zero for a month outside 1 to 12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    d = DAY_W'(30);
            4'd2:    d = leap ? DAY_W'(29) : DAY_W'(28);
            default: d = '0;
        endcase
        return d;
    endfunction

    // Zeller month term (13 * (mm + 1)) / 5 for mm in 3 to 14
    function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] mm);
        logic [5:0] t;
        case (mm)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[design/cdu_ctrl.sv]
// ----------------------------------------------------------------------------
// cdu_ctrl: sequencer of the calendar date unit
// Walks each transaction through the year split, validity check, weekday
// divisions and the month-by-month day count, and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cdu_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    output logic                   o_done,
    input  cdu_pkg::t_dp_sts       i_sts,
    output cdu_pkg::t_dp_cmd       o_cmd
);
    import cdu_pkg::*;

    t_state           r_state, n_state;
    logic             r_done;

    // Hold state and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_DONE);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_Q400;
                end
            end
            ST_Q400:  n_state = ST_R400;
            ST_R400:  n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_sts.date_ok) begin
                    n_state = ST_Q100;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_Q100:  n_state = ST_R100;
            ST_R100:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_Q7;
            ST_Q7:    n_state = ST_R7;
            ST_R7:    n_state = ST_MONTH;
            ST_MONTH: begin
                if (i_sts.month_fit) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath commands per state
    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_400;
        unique case (r_state)
            ST_IDLE:   o_cmd.load = start;
            ST_Q400: begin
                o_cmd.div_quo = 1'b1;
                o_cmd.div_sel = DIV_400;
            end
            ST_R400: begin
                o_cmd.div_rem = 1'b1;
                o_cmd.div_sel = DIV_400;
            end
            ST_CHECK:  o_cmd.load_yy = 1'b1;
            ST_Q100: begin
                o_cmd.div_quo = 1'b1;
                o_cmd.div_sel = DIV_100;
            end
            ST_R100: begin
                o_cmd.div_rem = 1'b1;
                o_cmd.div_sel = DIV_100;
            end
            ST_SUM:    o_cmd.load_w = 1'b1;
            ST_Q7: begin
                o_cmd.div_quo = 1'b1;
                o_cmd.div_sel = DIV_7;
            end
            ST_R7: begin
                o_cmd.div_rem = 1'b1;
                o_cmd.div_sel = DIV_7;
            end
            ST_MONTH:  o_cmd.month_step = ~i_sts.month_fit;
            ST_DONE:   o_cmd.out_load = 1'b1;
            default: ;
        endcase
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

[design/cdu_dp.sv]
// ----------------------------------------------------------------------------
// cdu_dp: datapath of the calendar date unit
// Input registers, a shared constant divider by 400, 100 or 7 (reciprocal
// multiply, then subtract), the Zeller sum, the running date of the day
// count and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cdu_dp #(
    parameter int ADD_DAYS_BITS = cdu_pkg::ADD_DAYS_BITS_DEF
) (
    input  wire                              i_clk,
    input  cdu_pkg::t_dp_cmd                 i_cmd,
    output cdu_pkg::t_dp_sts                 o_sts,
    input  wire [cdu_pkg::DAY_W-1:0]         i_day_in,
    input  wire [cdu_pkg::MONTH_W-1:0]       i_month_in,
    input  wire [cdu_pkg::YEAR_W-1:0]        i_year_in,
    input  wire [cdu_pkg::HOUR_W-1:0]        i_hour_in,
    input  wire [cdu_pkg::MINUTE_W-1:0]      i_minute_in,
    input  wire [ADD_DAYS_BITS-1:0]          i_add_days,
    output logic                             o_valid_res,
    output logic [cdu_pkg::WDAY_W-1:0]       o_weekday,
    output logic [cdu_pkg::DAY_W-1:0]        o_res_day,
    output logic [cdu_pkg::MONTH_W-1:0]      o_end_month,
    output logic [cdu_pkg::YEAR_W-1:0]       o_end_year
);
    import cdu_pkg::*;

    // Running day count and running year widths
    localparam int ADD_W     = ADD_DAYS_BITS + 1;
    localparam int YEAR_SPAN = (2 ** ADD_DAYS_BITS + 31) / 365 + 2;
    localparam int RY_W      = $clog2(2 ** YEAR_W + YEAR_SPAN);

    logic [DAY_W-1:0]    r_day;
    logic [MONTH_W-1:0]  r_month;
    logic [YEAR_W-1:0]   r_year;
    logic [HOUR_W-1:0]   r_hour;
    logic [MINUTE_W-1:0] r_minute;
    logic [REM_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic                r_ok;
    logic [R400_W-1:0]   r_r400;
    logic [ADD_W-1:0]    r_rd;
    logic [MONTH_W-1:0]  r_rm;
    logic [RY_W-1:0]     r_ry;

    logic [RCP_W-1:0]    mul_k;
    logic [PROD_W-1:0]   prod;
    logic [QUO_W-1:0]    quo_calc;
    logic [REM_W-1:0]    dmul;
    logic                ok_comb;
    logic                jan_feb;
    logic [MONTH_W-1:0]  zel_mm;
    logic [REM_W-1:0]    zel_yy;
    logic [10:0]         zel_w;
    logic [DAY_W-1:0]    lim;

    // Quotient step: multiply by the reciprocal of the divisor
    assign mul_k = (i_cmd.div_sel == DIV_7) ? RCP7_MUL : RCP100_MUL;
    assign prod  = PROD_W'(r_rem) * PROD_W'(mul_k);

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_400: quo_calc = QUO_W'(prod >> RCP400_SH);
            DIV_100: quo_calc = QUO_W'(prod >> RCP100_SH);
            default: quo_calc = QUO_W'(prod >> RCP7_SH);
        endcase
    end

    // Remainder step: take quotient times divisor off the dividend
    assign dmul = REM_W'(r_quo) * div_const(i_cmd.div_sel);

    // Date and time check; remainder holds the year modulo 400 here
    assign ok_comb = (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC) &&
                     (r_day != '0) && (r_hour <= HOUR_MAX) &&
                     (r_minute <= MINUTE_MAX) &&
                     (r_day <= month_days(r_month, leap_r400(r_rem[R400_W-1:0])));

    // January and February count as months 13 and 14 of the year before
    assign jan_feb = (r_month <= MONTH_FEB);
    assign zel_mm  = jan_feb ? (r_month + MONTH_W'(12)) : r_month;
    assign zel_yy  = REM_W'(r_year) + REM_W'(400) - REM_W'(jan_feb);

    // Zeller sum: remainder is K = year mod 100, quotient is J = year / 100
    assign zel_w = 11'(r_day) + 11'(zeller_month(zel_mm)) +
                   11'(r_rem[6:0]) + 11'(r_rem[6:2]) +
                   11'(r_quo[QUO_W-1:2]) + {1'b0, r_quo, 2'b00} + 11'(r_quo);

    // Length of the running month
    assign lim = month_days(r_rm, leap_r400(r_r400));

    assign o_sts.date_ok   = ok_comb;
    assign o_sts.month_fit = (r_rd <= ADD_W'(lim));

    // Capture inputs and run the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day    <= i_day_in;
            r_month  <= i_month_in;
            r_year   <= i_year_in;
            r_hour   <= i_hour_in;
            r_minute <= i_minute_in;
            r_rem    <= REM_W'(i_year_in);
            r_quo    <= '0;
        end else if (i_cmd.load_yy) begin
            r_ok   <= ok_comb;
            r_rem  <= zel_yy;
            r_quo  <= '0;
        end else if (i_cmd.load_w) begin
            r_rem <= REM_W'(zel_w);
        end else if (i_cmd.div_quo) begin
            r_quo <= quo_calc;
        end else if (i_cmd.div_rem) begin
            r_rem <= r_rem - dmul;
        end
    end

    // Running date: retire one month per step, wrap at December
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= {1'b0, i_add_days} + ADD_W'(i_day_in);
            r_rm <= i_month_in;
            r_ry <= RY_W'(i_year_in);
        end else if (i_cmd.load_yy) begin
            r_r400 <= r_rem[R400_W-1:0];
        end else if (i_cmd.month_step) begin
            r_rd <= r_rd - ADD_W'(lim);
            if (r_rm == MONTH_DEC) begin
                r_rm   <= MONTH_JAN;
                r_ry   <= r_ry + RY_W'(1);
                r_r400 <= (r_r400 == R400_LAST) ? '0 : (r_r400 + R400_W'(1));
            end else begin
                r_rm <= r_rm + MONTH_W'(1);
            end
        end
    end

    // Register the result; drop everything for an illegal date
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_valid_res <= r_ok;
            o_weekday   <= r_ok ? r_rem[WDAY_W-1:0] : '0;
            o_res_day   <= r_ok ? r_rd[DAY_W-1:0] : '0;
            o_end_month <= r_ok ? r_rm : '0;
            o_end_year  <= r_ok ? r_ry[YEAR_W-1:0] : '0;
        end
    end

endmodule

`default_nettype wire

[design/calendar_date_unit.sv]
// ----------------------------------------------------------------------------
// calendar_date_unit: Gregorian date check, Zeller weekday and day addition
// o_done pulses once the result registers load; the month-stepping loop makes
// the run time grow with the month ends crossed by the day count (about 135
// for 4095 days), and an illegal date or time reports straight after the
// check, skipping the weekday and day count. One transaction at a time: the
// next start is taken from the o_done cycle on. Synchronous active-low reset
// returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_unit #(
    parameter int ADD_DAYS_BITS = cdu_pkg::ADD_DAYS_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [cdu_pkg::DAY_W-1:0]         i_day_in,
    input  wire [cdu_pkg::MONTH_W-1:0]       i_month_in,
    input  wire [cdu_pkg::YEAR_W-1:0]        i_year_in,
    input  wire [cdu_pkg::HOUR_W-1:0]        i_hour_in,
    input  wire [cdu_pkg::MINUTE_W-1:0]      i_minute_in,
    input  wire [ADD_DAYS_BITS-1:0]          i_add_days,
    output logic                             o_done,
    output logic                             o_valid_res,
    output logic [cdu_pkg::WDAY_W-1:0]       o_weekday,
    output logic [cdu_pkg::DAY_W-1:0]        o_res_day,
    output logic [cdu_pkg::MONTH_W-1:0]      o_end_month,
    output logic [cdu_pkg::YEAR_W-1:0]       o_end_year
);
    import cdu_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    cdu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath
    cdu_dp #(
        .ADD_DAYS_BITS (ADD_DAYS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .i_hour_in   (i_hour_in),
        .i_minute_in (i_minute_in),
        .i_add_days  (i_add_days),
        .o_valid_res (o_valid_res),
        .o_weekday   (o_weekday),
        .o_res_day   (o_res_day),
        .o_end_month (o_end_month),
        .o_end_year  (o_end_year)
    );

endmodule

`default_nettype wire

[design/cdu_checker.sv]
// ----------------------------------------------------------------------------
// cdu_props: port-level checks for the calendar date unit
// Watches the command handshake, result strobe and result fields over time;
// bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module cdu_props (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    input  wire                              busy,
    input  wire                              o_done,
    input  wire                              o_valid_res,
    input  wire [cdu_pkg::WDAY_W-1:0]        o_weekday,
    input  wire [cdu_pkg::DAY_W-1:0]         o_res_day,
    input  wire [cdu_pkg::MONTH_W-1:0]       o_end_month,
    input  wire [cdu_pkg::YEAR_W-1:0]        o_end_year
);
    import cdu_pkg::*;

    // A taken transaction keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after a taken transaction");

    // The result strobe lasts one cycle and comes with the unit free
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy ##1 !o_done))
        else $error("result strobe longer than one cycle or unit busy");

    // An illegal date reports all result fields as zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |->
            (o_weekday == '0) && (o_res_day == '0) &&
            (o_end_month == '0) && (o_end_year == '0))
        else $error("nonzero result for an illegal date");

    // A legal result carries a real weekday, month and day
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_valid_res) |->
            (o_weekday <= WDAY_W'(6)) && (o_end_month >= MONTH_JAN) &&
            (o_end_month <= MONTH_DEC) && (o_res_day != '0))
        else $error("legal result out of calendar range");

endmodule

bind calendar_date_unit cdu_props u_cdu_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_valid_res (o_valid_res),
    .o_weekday   (o_weekday),
    .o_res_day   (o_res_day),
    .o_end_month (o_end_month),
    .o_end_year  (o_end_year)
);

`default_nettype wire
